// File: hw/rtl/assert_macros.svh
// assertion macros for the obstacle detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SOD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SOD_ASSERT_IMPLIES(label, ante, cons)

`define SOD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/sod_pkg.sv
// types and constants shared by the obstacle detector modules
`timescale 1ns / 1ps

package sod_pkg;

  localparam int READING_W = 10;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

  localparam logic [READING_W-1:0] THRESHOLD_RST = 10'd100;
  localparam logic [TICK_W-1:0]    SETTLE_RST    = 16'd200;
  localparam logic [TICK_W-1:0]    HOLD_RST      = 16'd1000;
  localparam logic [READING_W-1:0] SAMPLE_RST    = 10'd900;

  typedef struct packed {
    logic [READING_W-1:0] threshold;
    logic [TICK_W-1:0]    settle_ticks;
    logic [TICK_W-1:0]    hold_ticks;
  } sod_cfg_t;

  typedef struct packed {
    logic trigger_level;
    logic near_obstacle;
    logic sampled;
  } sod_res_t;

endpackage

// File: hw/rtl/sod_if.sv
// item channel interfaces for sensor readings and detector results
`timescale 1ns / 1ps

interface sod_in_if
  import sod_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] left_reading;
  logic [READING_W-1:0] right_reading;

  modport source (output valid, output left_reading, output right_reading, input ready);
  modport sink (input valid, input left_reading, input right_reading, output ready);
endinterface

interface sod_out_if
  import sod_pkg::*;
();
  logic valid;
  logic ready;
  logic trigger_level;
  logic near_obstacle;
  logic sampled;

  modport source (output valid, output trigger_level, output near_obstacle, output sampled,
                  input ready);
  modport sink (input valid, input trigger_level, input near_obstacle, input sampled,
                output ready);
endinterface

// File: hw/rtl/sod_cfg_regs.sv
// configuration registers with write port
`timescale 1ns / 1ps

module sod_cfg_regs
  import sod_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output sod_cfg_t              cfg
);

  sod_cfg_t cfg_r;
  sod_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg_nxt.threshold    = cfg_wdata[READING_W-1:0];
        CFG_SETTLE:    cfg_nxt.settle_ticks = cfg_wdata[TICK_W-1:0];
        CFG_HOLD:      cfg_nxt.hold_ticks   = cfg_wdata[TICK_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= THRESHOLD_RST;
      cfg_r.settle_ticks <= SETTLE_RST;
      cfg_r.hold_ticks   <= HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/sod_core.sv
// input register, trigger sequencer, sample history and obstacle flag
`timescale 1ns / 1ps

module sod_core
  import sod_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sod_cfg_t             cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [READING_W-1:0] in_left,
  input  logic [READING_W-1:0] in_right,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sod_res_t             res
);

  localparam logic [1:0] PH_TRIG  = 2'd0;
  localparam logic [1:0] PH_LOWER = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == TICK_MAX) ? TICK_MAX : v + TICK_W'(1);
  endfunction

  // input register
  logic                 s1_valid_r;
  logic [READING_W-1:0] left_r;
  logic [READING_W-1:0] right_r;

  // detector state
  logic [1:0]           phase_r,   phase_nxt;
  logic [TICK_W-1:0]    since_r,   since_nxt;
  logic [TICK_W-1:0]    hold_r,    hold_nxt;
  logic [READING_W-1:0] older_r,   older_nxt;
  logic [READING_W-1:0] newer_r,   newer_nxt;
  logic                 near_r,    near_nxt;
  logic                 trig_r,    trig_nxt;

  logic                 took;
  logic                 adv;
  logic [TICK_W-1:0]    since_inc;
  logic [TICK_W-1:0]    hold_inc;
  logic [READING_W-1:0] min_reading;

  assign adv      = s1_valid_r && res_ready;
  assign in_ready = !s1_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      left_r  <= in_left;
      right_r <= in_right;
    end
  end

  assign since_inc   = sat_inc(since_r);
  assign hold_inc    = sat_inc(hold_r);
  assign min_reading = (left_r < right_r) ? left_r : right_r;

  always_comb begin
    phase_nxt = phase_r;
    since_nxt = since_r;
    hold_nxt  = hold_inc;
    older_nxt = older_r;
    newer_nxt = newer_r;
    near_nxt  = near_r;
    trig_nxt  = trig_r;
    took      = 1'b0;
    unique case (phase_r)
      PH_LOWER: begin
        since_nxt = since_inc;
        trig_nxt  = 1'b0;
        phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        since_nxt = since_inc;
        if (since_inc > cfg.settle_ticks) begin
          took      = 1'b1;
          older_nxt = newer_r;
          newer_nxt = min_reading;
          if (newer_r < cfg.threshold && min_reading < cfg.threshold) begin
            near_nxt = 1'b1;
            hold_nxt = '0;
          end else if (hold_inc > cfg.hold_ticks) begin
            near_nxt = 1'b0;
          end
          phase_nxt = PH_TRIG;
        end
      end
      default: begin
        trig_nxt  = 1'b1;
        since_nxt = '0;
        phase_nxt = PH_LOWER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIG;
      since_r <= '0;
      hold_r  <= '0;
      older_r <= SAMPLE_RST;
      newer_r <= SAMPLE_RST;
      near_r  <= 1'b0;
      trig_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      since_r <= since_nxt;
      hold_r  <= hold_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      near_r  <= near_nxt;
      trig_r  <= trig_nxt;
    end
  end

  assign res_valid         = s1_valid_r;
  assign res.trigger_level = trig_nxt;
  assign res.near_obstacle = near_nxt;
  assign res.sampled       = took;

endmodule

// File: hw/rtl/sonar_obstacle_detector.sv
// obstacle detector top level: one tick item in, one result item out
// an accepted item is held in the input register, then passes through the
// detector state update into the output register, where out valid rises
// throughput: one item per cycle unless out_ch.ready stalls the output register,
// set by the state update between the input register and the output register
// reset: synchronous active-low rst_n clears the pipeline and the detector
// state and loads the register defaults; items in flight are dropped, none held
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sonar_obstacle_detector
  import sod_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sod_in_if.sink                in_ch,
  sod_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sod_cfg_t cfg;
  sod_res_t res;
  logic     res_valid;
  logic     res_ready;

  logic     out_valid_r;
  sod_res_t out_res_r;

  sod_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sod_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_left   (in_ch.left_reading),
    .in_right  (in_ch.right_reading),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = out_res_r.trigger_level;
  assign out_ch.near_obstacle = out_res_r.near_obstacle;
  assign out_ch.sampled       = out_res_r.sampled;

  `SOD_ASSERT_IMPLIES(a_sample_trig_low, out_valid_r && out_res_r.sampled, !out_res_r.trigger_level)
  `SOD_ASSERT_NEXT(a_result_lands, res_valid && res_ready, out_valid_r)
  `SOD_ASSERT_IMPLIES(a_stall_cause, !in_ch.ready, res_valid && out_valid_r && !out_ch.ready)
  `SOD_ASSERT_IMPLIES(a_sample_trig_state, res_valid && res.sampled, !res.trigger_level)

endmodule
